### hw/rtl/hbg_pkg.sv
`default_nettype none

package hbg_pkg;

  // Field widths of the stream items.
  localparam int PIXEL_W       = 8;
  localparam int INDEX_FIELD_W = 5;
  localparam int COUNT_FIELD_W = 23;
  localparam int GEOM_W        = 16;
  localparam int BAR_W_W       = 10;
  localparam int M_TDATA_W     = 88;

  // Configuration port.
  localparam int CFG_W       = 12;
  localparam int PDATA_W     = 32;
  localparam int PADDR_W     = 3;
  localparam int REG_SEL_BIT = 2;

  localparam logic REG_GRAPH_WIDTH  = 1'b0;
  localparam logic REG_GRAPH_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] GRAPH_WIDTH_RESET  = 12'd600;
  localparam logic [CFG_W-1:0] GRAPH_HEIGHT_RESET = 12'd300;

  // Request kinds carried in s_tuser.
  localparam logic REQ_PIXEL     = 1'b0;
  localparam logic REQ_FRAME_END = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BW_GO,
    S_BW_WAIT,
    S_READ,
    S_LEFT_GO,
    S_LEFT_WAIT,
    S_HT_GO,
    S_HT_WAIT,
    S_EMIT
  } bar_state_t;

  typedef struct packed {
    logic [GEOM_W-1:0]  left;
    logic [GEOM_W-1:0]  top;
    logic [BAR_W_W-1:0] width;
    logic [GEOM_W-1:0]  height;
  } bar_geom_t;

  typedef struct packed {
    logic              done;
    logic [GEOM_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

### hw/rtl/histogram_bar_graph.sv
`default_nettype none

// Channel  Direction  Payload
// s_       in         tdata: pixel_value; tuser: req_type
// m_       out        tdata: bar geometry and count; tuser: empty_frame; tlast: last_bar
// APB      in         graph_width at 0x0, graph_height at 0x4
//
// A pixel item is taken every cycle outside a bar pass; its count is read at
// the accepting edge and written back, incremented, to the bin memory in the
// next cycle, with forwarding between neighbouring pixels. A frame end item
// starts the bar pass, which holds s_tready low: the bar width, then per bin
// a read, the left edge and a 16-step division of the bar height, skipped
// for an empty frame. Synchronous reset clears the bins through per-entry
// valid bits, so no clearing pass is needed. A stalled m_ channel holds one
// bar in the output register and stops the pass at the next bar.

module histogram_bar_graph
  import hbg_pkg::*;
#(
  parameter int BIN_COUNT  = 32,
  parameter int COUNT_BITS = 23
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [PIXEL_W-1:0]   s_tdata,   // [7:0] pixel_value
  input  wire logic [0:0]           s_tuser,   // [0] req_type
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [4:0] bin_index, [27:5] bin_count, [43:28] bar_left, [59:44] bar_top,
  // [69:60] bar_width, [85:70] bar_height, [87:86] zero
  output logic      [M_TDATA_W-1:0] m_tdata,
  output logic      [0:0]           m_tuser,   // [0] empty_frame
  output logic                      m_tlast,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic      [PDATA_W-1:0]   prdata,
  output logic                      pready
);

  localparam int IW    = $clog2(BIN_COUNT);
  localparam int DEN_W = $clog2(2 * BIN_COUNT + 2);
  localparam int DW    = (COUNT_BITS > DEN_W) ? COUNT_BITS : DEN_W;

  logic [CFG_W-1:0]      graph_width;
  logic [CFG_W-1:0]      graph_height;
  logic                  cfg_write;
  logic                  in_accept;
  logic                  pix_valid;
  logic                  frame_end;
  logic                  idle;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  clear;
  logic [COUNT_BITS-1:0] max_count;
  logic                  div_start;
  logic [GEOM_W+DW-1:0]  div_num;
  logic [DW-1:0]         div_den;
  div_res_t              div_res;
  logic [IW-1:0]         out_idx;
  logic [COUNT_BITS-1:0] out_cnt;
  bar_geom_t             out_geom;
  logic                  out_empty;
  logic                  out_last;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      graph_width  <= GRAPH_WIDTH_RESET;
      graph_height <= GRAPH_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[REG_SEL_BIT] == REG_GRAPH_WIDTH) begin
        graph_width <= pwdata[CFG_W-1:0];
      end else begin
        graph_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[REG_SEL_BIT] == REG_GRAPH_HEIGHT) begin
      prdata = PDATA_W'(graph_height);
    end else begin
      prdata = PDATA_W'(graph_width);
    end
  end

  assign s_tready  = idle;
  assign in_accept = s_tvalid && s_tready;
  assign pix_valid = in_accept && (s_tuser[0] == REQ_PIXEL);
  assign frame_end = in_accept && (s_tuser[0] == REQ_FRAME_END);

  hbg_store #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_value (s_tdata),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_count  (rd_count),
    .clear     (clear),
    .max_count (max_count)
  );

  hbg_div #(
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  hbg_bars #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS),
    .DW         (DW)
  ) u_bars (
    .clk          (clk),
    .rst          (rst),
    .start        (frame_end),
    .idle         (idle),
    .graph_width  (graph_width),
    .graph_height (graph_height),
    .max_count    (max_count),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_count     (rd_count),
    .clear        (clear),
    .div_start    (div_start),
    .div_num      (div_num),
    .div_den      (div_den),
    .div_res      (div_res),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_idx      (out_idx),
    .out_cnt      (out_cnt),
    .out_geom     (out_geom),
    .out_empty    (out_empty),
    .out_last     (out_last)
  );

  assign m_tdata = M_TDATA_W'({out_geom.height, out_geom.width, out_geom.top, out_geom.left,
                               COUNT_FIELD_W'(out_cnt), INDEX_FIELD_W'(out_idx)});
  assign m_tuser = out_empty;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

### hw/rtl/hbg_ram.sv
`default_nettype none

module hbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hbg_store.sv
`default_nettype none

module hbg_store
  import hbg_pkg::*;
#(
  parameter int BIN_COUNT  = 32,
  parameter int COUNT_BITS = 23
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pix_valid,
  input  wire logic [PIXEL_W-1:0]           pix_value,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(BIN_COUNT)-1:0] rd_addr,
  output logic      [COUNT_BITS-1:0]        rd_count,
  input  wire logic                         clear,
  output logic      [COUNT_BITS-1:0]        max_count
);

  localparam int IW = $clog2(BIN_COUNT);
  localparam int PW = PIXEL_W + IW + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

  logic [PW-1:0]         bin_prod;
  logic [IW:0]           bin_full;
  logic [IW-1:0]         pix_bin;
  logic [IW-1:0]         ram_rd_addr;
  logic                  ram_rd_en;
  logic [COUNT_BITS-1:0] ram_rd_data;
  logic                  valid_q;
  logic [BIN_COUNT-1:0]  valid_bits;
  logic                  s1_valid;
  logic [IW-1:0]         s1_bin;
  logic                  last_valid;
  logic [IW-1:0]         last_bin;
  logic [COUNT_BITS-1:0] last_data;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] new_count;

  assign bin_prod = PW'(pix_value) * PW'(BIN_COUNT);
  assign bin_full = bin_prod[PW-1:PIXEL_W];

  always_comb begin
    if (bin_full >= (IW+1)'(BIN_COUNT)) begin
      pix_bin = IW'(BIN_COUNT - 1);
    end else begin
      pix_bin = bin_full[IW-1:0];
    end
  end

  assign ram_rd_en   = pix_valid | rd_en;
  assign ram_rd_addr = pix_valid ? pix_bin : rd_addr;

  hbg_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_bin),
    .wr_data (new_count),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // An entry never written since the last clear reads as zero.
  assign rd_count = valid_q ? ram_rd_data : '0;

  // The write of the previous pixel lands at the same edge as the read of
  // this one, so a hit on that bin takes the written value instead.
  assign cur_count = (last_valid && last_bin == s1_bin) ? last_data : rd_count;
  assign new_count = (cur_count == COUNT_LIMIT) ? cur_count : cur_count + 1'b1;

  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      valid_q <= valid_bits[ram_rd_addr];
    end
    s1_bin    <= pix_bin;
    last_bin  <= s1_bin;
    last_data <= new_count;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s1_valid   <= 1'b0;
      last_valid <= 1'b0;
      valid_bits <= '0;
      max_count  <= '0;
    end else begin
      s1_valid   <= pix_valid;
      last_valid <= s1_valid;
      if (s1_valid) begin
        valid_bits[s1_bin] <= 1'b1;
        if (new_count > max_count) begin
          max_count <= new_count;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hbg_div.sv
`default_nettype none

module hbg_div
  import hbg_pkg::*;
#(
  parameter int DW = 23
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [GEOM_W+DW-1:0] num,
  input  wire logic [DW-1:0]        den,
  output div_res_t                  res
);

  // Restoring division, one quotient bit a cycle. The callers guarantee
  // that the quotient fits in GEOM_W bits, so the upper part of the
  // numerator is already below the divisor.
  localparam int SW = $clog2(GEOM_W + 1);

  logic [DW-1:0]     rem;
  logic [GEOM_W-1:0] shq;
  logic [SW-1:0]     steps;
  logic              busy;
  logic              done;
  logic [DW:0]       trial;
  logic [DW:0]       den_ext;
  logic              ge;

  assign den_ext = {1'b0, den};
  assign trial   = {rem, shq[GEOM_W-1]};
  assign ge      = (trial >= den_ext);

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[GEOM_W+DW-1:GEOM_W];
      shq <= num[GEOM_W-1:0];
    end else if (busy) begin
      rem <= ge ? DW'(trial - den_ext) : trial[DW-1:0];
      shq <= {shq[GEOM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(GEOM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quo  = shq;

endmodule

`default_nettype wire

### hw/rtl/hbg_bars.sv
`default_nettype none

module hbg_bars
  import hbg_pkg::*;
#(
  parameter int BIN_COUNT  = 32,
  parameter int COUNT_BITS = 23,
  parameter int DW         = 23
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              idle,
  input  wire logic [CFG_W-1:0]             graph_width,
  input  wire logic [CFG_W-1:0]             graph_height,
  input  wire logic [COUNT_BITS-1:0]        max_count,
  output logic                              rd_en,
  output logic      [$clog2(BIN_COUNT)-1:0] rd_addr,
  input  wire logic [COUNT_BITS-1:0]        rd_count,
  output logic                              clear,
  output logic                              div_start,
  output logic      [GEOM_W+DW-1:0]         div_num,
  output logic      [DW-1:0]                div_den,
  input  div_res_t                          div_res,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [$clog2(BIN_COUNT)-1:0] out_idx,
  output logic      [COUNT_BITS-1:0]        out_cnt,
  output bar_geom_t                         out_geom,
  output logic                              out_empty,
  output logic                              out_last
);

  localparam int IW    = $clog2(BIN_COUNT);
  localparam int NW    = GEOM_W + DW;
  localparam int LPW   = GEOM_W + IW + 1;
  localparam int DEN_L = $clog2(2 * BIN_COUNT + 1);
  localparam int RSH   = LPW + DEN_L;
  localparam int PRW   = RSH + GEOM_W;
  // Division by the odd constant 2*BIN_COUNT+1 is a multiplication by its
  // rounded-up reciprocal, exact for every numerator below 2**LPW.
  localparam longint unsigned DENOM = 64'(2 * BIN_COUNT + 1);
  localparam longint unsigned RECIP = ((64'd1 << RSH) + DENOM - 64'd1) / DENOM;
  localparam logic [LPW:0] RECIP_C = (LPW+1)'(RECIP);
  localparam logic [IW-1:0] LAST_IDX = IW'(BIN_COUNT - 1);

  bar_state_t state, state_next;

  logic [IW-1:0]            idx;
  logic [COUNT_BITS-1:0]    cnt;
  logic [DW-1:0]            max_q;
  logic                     empty;
  logic [BAR_W_W-1:0]       bw;
  logic [GEOM_W-1:0]        left;
  logic [GEOM_W-1:0]        ht;
  logic [GEOM_W-1:0]        w16;
  logic [GEOM_W-1:0]        h16;
  logic [GEOM_W+IW:0]       left_prod;
  logic [GEOM_W+COUNT_BITS-1:0] ht_prod;
  logic [LPW-1:0]           q_num;
  logic [PRW-1:0]           q_prod;
  logic [GEOM_W-1:0]        q_quo;
  logic                     load_out;

  assign w16       = {graph_width, 4'b0000};
  assign h16       = {graph_height, 4'b0000};
  assign left_prod = LPW'(w16) * LPW'({idx, 1'b1});
  assign ht_prod   = (GEOM_W+COUNT_BITS)'(h16) * (GEOM_W+COUNT_BITS)'(cnt);
  assign q_prod    = PRW'(q_num) * PRW'(RECIP_C);
  assign q_quo     = q_prod[RSH +: GEOM_W];
  assign rd_addr   = idx;
  assign idle      = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    clear      = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_BW_GO;
        end
      end
      S_BW_GO: begin
        state_next = S_BW_WAIT;
      end
      S_BW_WAIT: begin
        state_next = S_READ;
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_LEFT_GO;
      end
      S_LEFT_GO: begin
        state_next = S_LEFT_WAIT;
      end
      S_LEFT_WAIT: begin
        state_next = empty ? S_EMIT : S_HT_GO;
      end
      S_HT_GO: begin
        div_start  = 1'b1;
        state_next = S_HT_WAIT;
      end
      S_HT_WAIT: begin
        if (div_res.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out = 1'b1;
          if (idx == LAST_IDX) begin
            clear      = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx   <= '0;
        q_num <= LPW'(w16);
      end
      S_BW_GO: begin
        // Taken here rather than at the frame end item, so that a pixel
        // still finishing in the store is already counted.
        max_q <= DW'(max_count);
        empty <= (max_count == '0);
      end
      S_BW_WAIT: begin
        bw <= BAR_W_W'(q_quo);
      end
      S_READ: begin
        q_num <= left_prod;
      end
      S_LEFT_GO: begin
        cnt <= rd_count;
      end
      S_LEFT_WAIT: begin
        left    <= q_quo;
        ht      <= '0;
        div_num <= NW'(ht_prod);
        div_den <= max_q;
      end
      S_HT_WAIT: begin
        if (div_res.done) begin
          ht <= div_res.quo;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          idx <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: the bar waits here while the next one is worked out.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx         <= idx;
      out_cnt         <= cnt;
      out_geom.left   <= left;
      out_geom.top    <= h16 - ht;
      out_geom.width  <= bw;
      out_geom.height <= ht;
      out_empty       <= empty;
      out_last        <= (idx == LAST_IDX);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hbg_check.sv
`default_nettype none

module hbg_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [87:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        m_tlast
);

  // Nothing comes out of reset pending.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("bar item pending after reset");

  // A waiting bar is neither dropped nor changed in its data or last flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled bar item changed");

  // While bars other than the last are out, the pass is still running.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken in the middle of a bar pass");

  // The pass may only finish once the last bar has taken the output register.
  a_busy_next: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready || (m_tvalid && m_tlast))
    else $error("bar pass ended before its last bar");

  // An empty frame shows flat bars.
  a_empty_flat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[85:70] == 16'd0)
    else $error("empty frame with non-zero bar height");

endmodule

bind histogram_bar_graph hbg_check u_check (.*);

`default_nettype wire

### bench/tb_top.sv
module tb_top;
  import hbg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS     = 32;
  localparam int DENOM    = 2 * BINS + 1;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_FIELD_W) - 1;
  localparam int RAND_ITEMS = 470;
  localparam int SETTLE     = 8;
  localparam int LIMIT      = 4000000;

  typedef struct {
    logic [INDEX_FIELD_W-1:0] index;
    logic [COUNT_FIELD_W-1:0] count;
    logic [GEOM_W-1:0]        left;
    logic [GEOM_W-1:0]        top;
    logic [BAR_W_W-1:0]       width;
    logic [GEOM_W-1:0]        height;
    logic                     empty;
    logic                     last;
  } bar_t;

  typedef struct {
    logic               req;
    logic [PIXEL_W-1:0] pix;
    bit                 typed;
    logic [BAR_W_W-1:0] width;
    logic [GEOM_W-1:0]  top;
    logic [GEOM_W-1:0]  height;
    logic               empty;
  } stim_row_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [PIXEL_W-1:0]   s_tdata  = '0;   // [7:0] pixel_value
  logic [0:0]           s_tuser  = '0;   // [0] req_type
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [4:0] bin_index, [27:5] bin_count, [43:28] bar_left, [59:44] bar_top,
  // [69:60] bar_width, [85:70] bar_height, [87:86] zero
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;         // [0] empty_frame
  logic                 m_tlast;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [PDATA_W-1:0]   pwdata   = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  histogram_bar_graph u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Histogram shadow and the bars still owed by the block.
  longint unsigned hist[BINS];
  longint unsigned peak;
  longint unsigned cfg_w = GRAPH_WIDTH_RESET;
  longint unsigned cfg_h = GRAPH_HEIGHT_RESET;
  bar_t            bars_due[$];

  int  errors = 0;
  int  cycles = 0;
  bit  no_gaps = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void tally_pixel(logic [PIXEL_W-1:0] pix);
    int unsigned b;
    b = (int'(pix) * BINS) >> PIXEL_W;
    if (hist[b] < CNT_MAX) hist[b]++;
    if (hist[b] > peak) peak = hist[b];
  endfunction

  function automatic void emit_bars();
    longint unsigned w16, h16, bw, ht;
    bar_t            bar;
    w16 = 16 * cfg_w;
    h16 = 16 * cfg_h;
    bw  = w16 / DENOM;
    for (int i = 0; i < BINS; i++) begin
      ht         = (peak == 0) ? 0 : (h16 * hist[i]) / peak;
      bar.index  = INDEX_FIELD_W'(i);
      bar.count  = COUNT_FIELD_W'(hist[i]);
      bar.left   = GEOM_W'((w16 * (2 * i + 1)) / DENOM);
      bar.top    = GEOM_W'(h16 - ht);
      bar.width  = BAR_W_W'(bw);
      bar.height = GEOM_W'(ht);
      bar.empty  = (peak == 0);
      bar.last   = (i == BINS - 1);
      bars_due.push_back(bar);
    end
    foreach (hist[i]) hist[i] = 0;
    peak = 0;
  endfunction

  // Result side: check every accepted bar, then decide the next tready.
  always @(posedge clk) begin
    bar_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.index  = m_tdata[4:0];
      got.count  = m_tdata[27:5];
      got.left   = m_tdata[43:28];
      got.top    = m_tdata[59:44];
      got.width  = m_tdata[69:60];
      got.height = m_tdata[85:70];
      got.empty  = m_tuser[0];
      got.last   = m_tlast;
      if (bars_due.size() == 0) begin
        $error("bar for bin %0d arrived with nothing expected", got.index);
        errors++;
      end else begin
        want = bars_due.pop_front();
        check_field("bin_index", want.index, got.index);
        check_field("bin_count", want.count, got.count);
        check_field("bar_left", want.left, got.left);
        check_field("bar_top", want.top, got.top);
        check_field("bar_width", want.width, got.width);
        check_field("bar_height", want.height, got.height);
        check_field("empty_frame", want.empty, got.empty);
        check_field("last_bar", want.last, got.last);
      end
    end
    m_tready <= no_gaps || ($urandom_range(99) >= 10);
  end

  task automatic send_item(input logic req, input logic [PIXEL_W-1:0] pix);
    while (!no_gaps && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    if (req == REQ_FRAME_END) emit_bars();
    else tally_pixel(pix);
  endtask

  // Write one register, then read it back; the upper pwdata bits are noise.
  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
    logic [PADDR_W-1:0] addr;
    addr = PADDR_W'(sel) << REG_SEL_BIT;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(PDATA_W - CFG_W)'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_GRAPH_WIDTH) cfg_w = val;
    else cfg_h = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", PDATA_W'(val), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (bars_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Empty frames at the reset setting have a fixed shape: 9600/65 wide, flat at 4800.
  stim_row_t directed[] = '{
    '{REQ_FRAME_END, 8'h00, 1'b1, 10'd147, 16'd4800, 16'd0, 1'b1},
    '{REQ_PIXEL,     8'h00, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'hFF, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'h07, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'h08, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'hF7, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'hF8, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'h80, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'h7F, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'hFF, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'hFF, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'h55, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_PIXEL,     8'hAA, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_FRAME_END, 8'hFF, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_FRAME_END, 8'h5A, 1'b1, 10'd147, 16'd4800, 16'd0, 1'b1},
    '{REQ_PIXEL,     8'h01, 1'b0, '0, '0, '0, 1'b0},
    '{REQ_FRAME_END, 8'hA5, 1'b0, '0, '0, '0, 1'b0}
  };

  logic [CFG_W-1:0] edge_w[6] = '{12'd4095, 12'd1, 12'd0, 12'd600, 12'd4095, 12'd1};
  logic [CFG_W-1:0] edge_h[6] = '{12'd4095, 12'd1, 12'd300, 12'd0, 12'd1, 12'd4095};

  initial begin
    int sent, phase, npix, mode, hot0, hot1;
    logic [PIXEL_W-1:0] pix;
    sent  = 0;
    phase = 0;
    foreach (hist[i]) hist[i] = 0;
    peak = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      send_item(directed[r].req, directed[r].pix);
      if (directed[r].typed) begin
        for (int k = bars_due.size() - BINS; k < bars_due.size(); k++) begin
          bars_due[k].width  = directed[r].width;
          bars_due[k].top    = directed[r].top;
          bars_due[k].height = directed[r].height;
          bars_due[k].empty  = directed[r].empty;
        end
      end
    end
    s_tvalid <= 1'b0;
    drain();

    while (sent < RAND_ITEMS) begin
      if (phase < 6) begin
        write_reg(REG_GRAPH_WIDTH, edge_w[phase]);
        write_reg(REG_GRAPH_HEIGHT, edge_h[phase]);
      end else begin
        write_reg(REG_GRAPH_WIDTH, CFG_W'($urandom_range(4095, 1)));
        write_reg(REG_GRAPH_HEIGHT, CFG_W'($urandom_range(4095, 1)));
      end
      no_gaps = (phase % 6 == 3);
      repeat ($urandom_range(2, 1)) begin
        // Mostly plain random frames; some empty, some piled into two bins.
        mode = $urandom_range(9);
        npix = (mode == 0) ? 0 : (mode < 3) ? $urandom_range(120, 20) : $urandom_range(40, 1);
        hot0 = $urandom_range(BINS - 1);
        hot1 = $urandom_range(BINS - 1);
        repeat (npix) begin
          if (mode >= 3) pix = PIXEL_W'($urandom_range(255));
          else pix = PIXEL_W'(((($urandom_range(3) == 0) ? hot1 : hot0) << 3)
                              | $urandom_range(7));
          send_item(REQ_PIXEL, pix);
          sent++;
        end
        send_item(REQ_FRAME_END, PIXEL_W'($urandom_range(255)));
        sent++;
      end
      s_tvalid <= 1'b0;
      drain();
      phase++;
    end

    no_gaps = 1'b0;
    s_tvalid <= 1'b0;
    while (bars_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
